[rtl/lsag_pkg.sv]
// Shared types and constants for the load/store address generator.
// No dependencies.
package lsag_pkg;

   localparam int unsigned WORD_W = 32;

   localparam logic [WORD_W-1:0] PC_ADJUST  = 32'd8;
   localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;
   localparam logic [3:0]        RN_PC      = 4'd15;

   typedef enum logic [1:0] {
      MODE_WORD  = 2'd0,
      MODE_HALF  = 2'd1,
      MODE_MULTI = 2'd2
   } lsag_mode_type;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } lsag_shift_type;

   // P and U bits of a block transfer
   typedef enum logic [1:0] {
      BLOCK_DA = 2'd0,
      BLOCK_IA = 2'd1,
      BLOCK_DB = 2'd2,
      BLOCK_IB = 2'd3
   } lsag_block_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [WORD_W-1:0] instr;
      logic [WORD_W-1:0] base_value;
      logic [WORD_W-1:0] index_value;
      logic              carry_in;
   } lsag_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] start_addr;
      logic [WORD_W-1:0] end_addr;
      logic              wb_enable;
      logic [WORD_W-1:0] wb_value;
      logic              bad_form;
   } lsag_rsp_type;

endpackage

[rtl/arm_load_store_address_gen_top.sv]
// Load/store address generator for ARM addressing modes 2, 3 and 4, top level.
// Depends on lsag_pkg, lsag_offset and lsag_addr.
//
// One item is accepted every clock cycle while req_stall is low. Each item
// passes through an input register, then one pass of offset, adder and
// popcount logic, then a result register, from which the result is shown and
// leaves while rsp_stall is low. The result register advances whenever it is
// empty or rsp_stall is low, and the input register advances whenever the
// result register does, so req_stall is high only while both registers hold
// items and rsp_stall is high.
module arm_load_store_address_gen_top
   import lsag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [WORD_W-1:0] req_instr,
   input  logic [WORD_W-1:0] req_base_value,
   input  logic [WORD_W-1:0] req_index_value,
   input  logic              req_carry_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_start_addr,
   output logic [WORD_W-1:0] rsp_end_addr,
   output logic              rsp_wb_enable,
   output logic [WORD_W-1:0] rsp_wb_value,
   output logic              rsp_bad_form
);

   logic         in_vld_ff, in_vld_in;
   logic         out_vld_ff, out_vld_in;
   lsag_req_type in_req_ff, in_req_in;
   lsag_rsp_type out_rsp_ff, out_rsp_in;
   logic         out_adv, in_adv;
   logic [WORD_W-1:0] offset;
   lsag_rsp_type calc_rsp;

   assign out_adv   = !out_vld_ff || !rsp_stall;
   assign in_adv    = !in_vld_ff || out_adv;
   assign req_stall = !in_adv;

   lsag_offset u_offset (
      .req    (in_req_ff),
      .offset (offset)
   );

   lsag_addr u_addr (
      .req    (in_req_ff),
      .offset (offset),
      .rsp    (calc_rsp)
   );

   always_comb begin
      in_vld_in  = in_adv ? req_valid : in_vld_ff;
      out_vld_in = out_adv ? in_vld_ff : out_vld_ff;
      in_req_in  = in_req_ff;
      if (in_adv && req_valid) begin
         in_req_in = '{mode:        req_type,
                       instr:       req_instr,
                       base_value:  req_base_value,
                       index_value: req_index_value,
                       carry_in:    req_carry_in};
      end
      out_rsp_in = (out_adv && in_vld_ff) ? calc_rsp : out_rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_start_addr = out_rsp_ff.start_addr;
   assign rsp_end_addr   = out_rsp_ff.end_addr;
   assign rsp_wb_enable  = out_rsp_ff.wb_enable;
   assign rsp_wb_value   = out_rsp_ff.wb_value;
   assign rsp_bad_form   = out_rsp_ff.bad_form;

endmodule

[rtl/lsag_offset.sv]
// Offset former for modes 2 and 3: immediates and the scaled register shifter.
// Depends on lsag_pkg.
module lsag_offset
   import lsag_pkg::*;
(
   input  lsag_req_type      req,
   output logic [WORD_W-1:0] offset
);

   logic [4:0]          amt;
   logic [1:0]          kind;
   logic [WORD_W-1:0]   rmv;
   logic [WORD_W-1:0]   shifted;
   logic [2*WORD_W-1:0] dbl;

   assign amt  = req.instr[11:7];
   assign kind = req.instr[6:5];
   assign rmv  = req.index_value;
   assign dbl  = {rmv, rmv} >> amt;

   always_comb begin
      case (kind)
         SHIFT_LSL: shifted = rmv << amt;
         SHIFT_LSR: shifted = (amt == 5'd0) ? '0 : (rmv >> amt);
         SHIFT_ASR: shifted = (amt == 5'd0) ? WORD_W'($signed(rmv) >>> 31)
                                            : WORD_W'($signed(rmv) >>> amt);
         default:   shifted = (amt == 5'd0) ? {req.carry_in, rmv[WORD_W-1:1]}
                                            : dbl[WORD_W-1:0];
      endcase
   end

   always_comb begin
      if (req.mode == MODE_WORD) begin
         offset = req.instr[25] ? shifted : {20'd0, req.instr[11:0]};
      end else begin
         offset = req.instr[22] ? {24'd0, req.instr[11:8], req.instr[3:0]} : rmv;
      end
   end

endmodule

[rtl/lsag_addr.sv]
// Address, end address and base write-back for modes 2, 3 and 4.
// Depends on lsag_pkg; takes the offset from lsag_offset.
module lsag_addr
   import lsag_pkg::*;
(
   input  lsag_req_type      req,
   input  logic [WORD_W-1:0] offset,
   output lsag_rsp_type      rsp
);

   logic              p, u, w;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] moved;
   logic [4:0]        cnt;
   logic [WORD_W-1:0] bytes;

   assign p = req.instr[24];
   assign u = req.instr[23];
   assign w = req.instr[21];

   assign base  = (req.instr[19:16] == RN_PC) ? req.base_value + PC_ADJUST : req.base_value;
   assign moved = u ? base + offset : base - offset;

   always_comb begin
      cnt = '0;
      for (int i = 0; i < 16; i++) begin
         cnt = cnt + 5'(req.instr[i]);
      end
   end

   assign bytes = {25'd0, cnt, 2'b00};

   always_comb begin
      rsp = '0;
      unique case (req.mode)
         MODE_WORD, MODE_HALF: begin
            if (!p) begin
               rsp.start_addr = base;
               if (req.mode == MODE_HALF && w) begin
                  rsp.bad_form = 1'b1;
               end else begin
                  rsp.wb_enable = 1'b1;
                  rsp.wb_value  = moved;
               end
            end else begin
               rsp.start_addr = moved;
               if (w) begin
                  rsp.wb_enable = 1'b1;
                  rsp.wb_value  = moved;
               end
            end
            rsp.end_addr = rsp.start_addr;
         end
         MODE_MULTI: begin
            unique case (lsag_block_type'({p, u}))
               BLOCK_DA: begin
                  rsp.start_addr = base - bytes + WORD_BYTES;
                  rsp.end_addr   = base;
               end
               BLOCK_IA: begin
                  rsp.start_addr = base;
                  rsp.end_addr   = base + bytes - WORD_BYTES;
               end
               BLOCK_DB: begin
                  rsp.start_addr = base - bytes;
                  rsp.end_addr   = base - WORD_BYTES;
               end
               default: begin
                  rsp.start_addr = base + WORD_BYTES;
                  rsp.end_addr   = base + bytes;
               end
            endcase
            if (w) begin
               rsp.wb_enable = 1'b1;
               rsp.wb_value  = u ? base + bytes : base - bytes;
            end
         end
         default: rsp = '0;
      endcase
   end

endmodule

[rtl/lsag_checker.sv]
// Port-level checks for the load/store address generator, bound to the top level.
// Depends on lsag_pkg and arm_load_store_address_gen_top.
module lsag_checker
   import lsag_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [WORD_W-1:0] rsp_start_addr,
   input logic [WORD_W-1:0] rsp_end_addr,
   input logic              rsp_wb_enable,
   input logic [WORD_W-1:0] rsp_wb_value,
   input logic              rsp_bad_form
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_addr)
                                 && $stable(rsp_wb_value))
      else $error("stalled item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item shown right after reset");

   a_bad_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_form |-> !rsp_wb_enable
                                    && rsp_start_addr == rsp_end_addr)
      else $error("malformed form with write-back or split range");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wb_enable |-> rsp_wb_value == '0)
      else $error("write-back value without write-back");

endmodule

bind arm_load_store_address_gen_top lsag_checker u_lsag_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_start_addr (rsp_start_addr),
   .rsp_end_addr   (rsp_end_addr),
   .rsp_wb_enable  (rsp_wb_enable),
   .rsp_wb_value   (rsp_wb_value),
   .rsp_bad_form   (rsp_bad_form)
);

[test/tb_arm_load_store_address_gen_top.sv]
// Testbench for arm_load_store_address_gen_top: directed and random load/store items,
// results predicted in the testbench and checked field by field, in order.
// Depends on lsag_pkg and the address generator RTL.
module tb_arm_load_store_address_gen_top;
   import lsag_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int RANDOM_PER_PHASE = 428;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [WORD_W-1:0] req_instr;
   logic [WORD_W-1:0] req_base_value;
   logic [WORD_W-1:0] req_index_value;
   logic              req_carry_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [WORD_W-1:0] rsp_start_addr;
   logic [WORD_W-1:0] rsp_end_addr;
   logic              rsp_wb_enable;
   logic [WORD_W-1:0] rsp_wb_value;
   logic              rsp_bad_form;

   lsag_rsp_type pending_addrs[$];
   int send_idle_pct;
   int recv_stall_pct;
   int stall_hold;
   int cycles;
   int mismatches;
   int items_sent;
   int results_checked;
   int items_by_mode[4];

   arm_load_store_address_gen_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_instr       (req_instr),
      .req_base_value  (req_base_value),
      .req_index_value (req_index_value),
      .req_carry_in    (req_carry_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_start_addr  (rsp_start_addr),
      .rsp_end_addr    (rsp_end_addr),
      .rsp_wb_enable   (rsp_wb_enable),
      .rsp_wb_value    (rsp_wb_value),
      .rsp_bad_form    (rsp_bad_form)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] scaled_index(logic [31:0] instr, logic [31:0] rm,
                                                logic carry);
      logic [4:0] amt;
      amt = instr[11:7];
      case (lsag_shift_type'(instr[6:5]))
         SHIFT_LSL: return rm << amt;
         SHIFT_LSR: return (amt == 5'd0) ? 32'd0 : rm >> amt;
         SHIFT_ASR: return (amt == 5'd0) ? {32{rm[31]}} : 32'($signed(rm) >>> amt);
         default:   return (amt == 5'd0) ? {carry, rm[31:1]}
                                         : (rm >> amt) | (rm << (6'd32 - {1'b0, amt}));
      endcase
   endfunction

   function automatic lsag_rsp_type predict_addresses(lsag_req_type r);
      lsag_rsp_type o;
      logic [31:0] base;
      logic [31:0] off;
      logic [31:0] moved;
      logic [31:0] bytes;
      o = '0;
      base = r.base_value;
      if (r.instr[19:16] == RN_PC)
         base = base + PC_ADJUST;
      if (r.mode == MODE_WORD || r.mode == MODE_HALF) begin
         if (r.mode == MODE_WORD)
            off = r.instr[25] ? scaled_index(r.instr, r.index_value, r.carry_in)
                              : {20'd0, r.instr[11:0]};
         else
            off = r.instr[22] ? {24'd0, r.instr[11:8], r.instr[3:0]} : r.index_value;
         moved = r.instr[23] ? base + off : base - off;
         if (!r.instr[24]) begin
            o.start_addr = base;
            if (r.mode == MODE_HALF && r.instr[21]) begin
               o.bad_form = 1'b1;
            end else begin
               o.wb_enable = 1'b1;
               o.wb_value = moved;
            end
         end else begin
            o.start_addr = moved;
            if (r.instr[21]) begin
               o.wb_enable = 1'b1;
               o.wb_value = moved;
            end
         end
         o.end_addr = o.start_addr;
      end else if (r.mode == MODE_MULTI) begin
         bytes = 32'($countones(r.instr[15:0])) * WORD_BYTES;
         case (lsag_block_type'(r.instr[24:23]))
            BLOCK_DA: begin
               o.start_addr = base - bytes + WORD_BYTES;
               o.end_addr = base;
            end
            BLOCK_IA: begin
               o.start_addr = base;
               o.end_addr = base + bytes - WORD_BYTES;
            end
            BLOCK_DB: begin
               o.start_addr = base - bytes;
               o.end_addr = base - WORD_BYTES;
            end
            default: begin
               o.start_addr = base + WORD_BYTES;
               o.end_addr = base + bytes;
            end
         endcase
         if (r.instr[21]) begin
            o.wb_enable = 1'b1;
            o.wb_value = r.instr[23] ? base + bytes : base - bytes;
         end
      end
      return o;
   endfunction

   // cond AL, P U W Rn, bit 25 and bit 22 as given, low half verbatim
   function automatic logic [31:0] ls_word(logic p, logic u, logic b25, logic b22, logic w,
                                           logic [3:0] rn, logic [15:0] low);
      return {4'hE, 2'b01, b25, p, u, b22, w, 1'b1, rn, low};
   endfunction

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'hFFFF_FFF8;
         default: return $urandom;
      endcase
   endfunction

   function automatic lsag_req_type random_request();
      lsag_req_type r;
      r.mode = ($urandom_range(15) == 0) ? MODE_UNUSED : 2'($urandom_range(MODE_MULTI));
      r.instr = $urandom;
      if ($urandom_range(7) == 0)
         r.instr[19:16] = RN_PC;
      if ($urandom_range(3) == 0)
         r.instr[11:7] = 5'd0;
      if (r.mode == MODE_MULTI) begin
         case ($urandom_range(9))
            0: r.instr[15:0] = 16'h0000;
            1: r.instr[15:0] = 16'hFFFF;
            2: r.instr[15:0] = 16'h0001 << $urandom_range(15);
            default: ;
         endcase
      end
      r.base_value = ($urandom_range(3) == 0) ? edgy_word() : $urandom;
      r.index_value = ($urandom_range(3) == 0) ? edgy_word() : $urandom;
      r.carry_in = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic send_item(lsag_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= item.mode;
      req_instr <= item.instr;
      req_base_value <= item.base_value;
      req_index_value <= item.index_value;
      req_carry_in <= item.carry_in;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_addrs.push_back(predict_addresses(item));
      items_sent++;
      items_by_mode[item.mode]++;
   endtask

   task automatic send_fields(logic [1:0] mode, logic [31:0] instr, logic [31:0] base,
                              logic [31:0] index, logic carry);
      lsag_req_type r;
      r.mode = mode;
      r.instr = instr;
      r.base_value = base;
      r.index_value = index;
      r.carry_in = carry;
      send_item(r);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_addrs.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_word_immediate();
      send_fields(MODE_WORD, ls_word(1, 1, 0, 0, 0, 4'd1, 16'h0000), 32'h1000_0000, '0, 0);
      send_fields(MODE_WORD, ls_word(1, 0, 0, 0, 1, 4'd2, 16'h0FFF), 32'h0000_0100, '1, 1);
      send_fields(MODE_WORD, ls_word(0, 1, 0, 0, 1, 4'd3, 16'h0ABC), 32'hFFFF_FF00, '0, 0);
      send_fields(MODE_WORD, ls_word(1, 1, 0, 0, 1, RN_PC, 16'h0004), 32'hFFFF_FFFC, '0, 0);
   endtask

   task automatic test_word_shifts();
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 0, 4'd1, {4'h0, 5'd0, SHIFT_LSL, 1'b0, 4'h2}),
                  32'h0000_1000, 32'h1234_5678, 0);
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 0, 4'd1, {4'h0, 5'd31, SHIFT_LSL, 1'b0, 4'h2}),
                  32'h0000_1000, 32'hFFFF_FFFF, 0);
      send_fields(MODE_WORD, ls_word(1, 0, 1, 0, 1, 4'd1, {4'h0, 5'd0, SHIFT_LSR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'hFFFF_FFFF, 1);
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 0, 4'd1, {4'h0, 5'd1, SHIFT_LSR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'h8000_0001, 0);
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 1, 4'd1, {4'h0, 5'd0, SHIFT_ASR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'h8000_0000, 0);
      send_fields(MODE_WORD, ls_word(0, 0, 1, 0, 0, 4'd1, {4'h0, 5'd5, SHIFT_ASR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'hF000_0F00, 0);
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 0, 4'd1, {4'h0, 5'd0, SHIFT_ROR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'h0000_0003, 1);
      send_fields(MODE_WORD, ls_word(1, 1, 1, 0, 0, 4'd1, {4'h0, 5'd7, SHIFT_ROR, 1'b0, 4'h2}),
                  32'h0000_1000, 32'h0000_00FF, 0);
   endtask

   task automatic test_halfword();
      send_fields(MODE_HALF, ls_word(1, 1, 0, 1, 1, 4'd4, 16'h0FBF), 32'h2000_0000, '0, 0);
      send_fields(MODE_HALF, ls_word(1, 0, 0, 0, 0, 4'd4, 16'h00B3), 32'h0000_0010,
                  32'h0000_0020, 0);
      send_fields(MODE_HALF, ls_word(0, 1, 0, 1, 1, 4'd4, 16'h01B1), 32'h3000_0000, '1, 1);
      send_fields(MODE_HALF, ls_word(0, 0, 0, 0, 0, 4'd4, 16'h00B5), 32'h3000_0000,
                  32'h0000_0040, 0);
      send_fields(MODE_HALF, ls_word(1, 1, 0, 1, 0, RN_PC, 16'h02B2), 32'h0000_8000, '0, 0);
   endtask

   task automatic test_multiple();
      send_fields(MODE_MULTI, ls_word(0, 1, 0, 0, 1, 4'd13, 16'h00F0), 32'h0000_1000, '0, 0);
      send_fields(MODE_MULTI, ls_word(1, 1, 0, 0, 0, 4'd13, 16'h8001), 32'h0000_1000, '0, 0);
      send_fields(MODE_MULTI, ls_word(0, 0, 0, 0, 1, 4'd13, 16'h000F), 32'h0000_0004, '0, 0);
      send_fields(MODE_MULTI, ls_word(1, 0, 0, 0, 1, 4'd13, 16'h4000), 32'h0000_0000, '0, 0);
      send_fields(MODE_MULTI, ls_word(0, 1, 0, 0, 1, 4'd13, 16'h0000), 32'hFFFF_FFFC, '0, 0);
      send_fields(MODE_MULTI, ls_word(1, 1, 0, 0, 1, RN_PC, 16'hFFFF), 32'hFFFF_FFF0, '0, 0);
   endtask

   task automatic test_unused_selector();
      send_fields(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
   endtask

   task automatic run_random(int count, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count)
         send_item(random_request());
      wait_drained();
   endtask

   task automatic test_random_phases();
      run_random(RANDOM_PER_PHASE, 0, 0);
      run_random(RANDOM_PER_PHASE, 81, 0);
      run_random(RANDOM_PER_PHASE, 0, 81);
      run_random(RANDOM_PER_PHASE, 24, 24);
   endtask

   // receiver holds off while items keep coming, so the pipeline fills and stalls its input
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stall_hold = HOLD_OFF_CYCLES;
      repeat (24)
         send_item(random_request());
      wait_drained();
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      lsag_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_addrs.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
         end else begin
            want = pending_addrs.pop_front();
            check_field("start_addr", want.start_addr, rsp_start_addr);
            check_field("end_addr", want.end_addr, rsp_end_addr);
            check_field("wb_enable", 32'(want.wb_enable), 32'(rsp_wb_enable));
            check_field("wb_value", want.wb_value, rsp_wb_value);
            check_field("bad_form", 32'(want.bad_form), 32'(rsp_bad_form));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0;
      req_instr = '0;
      req_base_value = '0;
      req_index_value = '0;
      req_carry_in = 1'b0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stall_hold = 0;
      cycles = 0;
      mismatches = 0;
      items_sent = 0;
      results_checked = 0;
      items_by_mode = '{0, 0, 0, 0};
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_word_immediate();
      test_word_shifts();
      test_halfword();
      test_multiple();
      test_unused_selector();
      wait_drained();
      test_random_phases();
      test_backpressure();

      repeat (8)
         @(posedge clock);
      $display("%0d items (word %0d, half %0d, multiple %0d, unused %0d), %0d results checked",
               items_sent, items_by_mode[0], items_by_mode[1], items_by_mode[2],
               items_by_mode[3], results_checked);
      $display("idle mixes: none, sender 81%%, receiver 81%%, both 24%%, %0d-cycle hold-off",
               HOLD_OFF_CYCLES);
      if (mismatches == 0 && pending_addrs.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
